FILE: rtl/core/llss_pkg.sv
// Shared types and constants for the least-load server select block.
`timescale 1ns / 1ps
`default_nettype none

package llss_pkg;

    // table size default and fixed field widths
    localparam int DEF_MAX_SERVERS = 16;
    localparam int IDX_W           = 4;
    localparam int CNT_W           = 5;
    localparam int PORT_W          = 16;
    localparam int CNT32_W         = 32;
    localparam int ENTRY_W         = PORT_W + 2 * CNT32_W;
    localparam int ALIVE_N         = 2 ** IDX_W;

    // one candidate entry as read back from the table
    typedef struct packed {
        logic [CNT_W-1:0]   idx;
        logic [PORT_W-1:0]  port;
        logic [CNT32_W-1:0] total;
        logic [CNT32_W-1:0] fail;
    } t_cand;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic load;
    } t_cmp_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/least_load_server_select_top.sv
// Top level of the least-load server select block: table, scan sequencer, output register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries update and select beats.
//   An update (i_kind = 0) writes one table entry in the cycle it is accepted
//   and gives no result; the block is ready again on the next cycle.
//   A select (i_kind = 1) scans entries 0 .. min(active_servers, MAX_SERVERS)-1
//   through one comparator, one entry per cycle, reading port and counts from
//   a RAM with registered read. o_in_stall stays high until the result has
//   entered the output register, so a new select is taken only once the
//   previous result is registered.
//   Output channel (o_out_valid / i_out_stall) holds the result in a register;
//   while the receiver stalls, the beat holds and a finished scan waits for it.
//   Configuration: i_cfg_we writes active_servers (5 bits); the user is to write it only
//   while the block idles (not enforced by the block). Reset (synchronous, active low)
//   marks every entry dead, sets active_servers to 1 and empties the output register.
//   Port and count storage is not cleared; an entry is used only after it is written.
`timescale 1ns / 1ps
`default_nettype none

module least_load_server_select_top
    import llss_pkg::*;
#(
    parameter int MAX_SERVERS = DEF_MAX_SERVERS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CNT_W-1:0]    i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_kind,
    input  wire logic [IDX_W-1:0]    i_entry_index,
    input  wire logic [PORT_W-1:0]   i_server_port,
    input  wire logic                i_server_alive,
    input  wire logic [CNT32_W-1:0]  i_total_count,
    input  wire logic [CNT32_W-1:0]  i_fail_count,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_found,
    output logic [PORT_W-1:0]        o_best_port,
    output logic [IDX_W-1:0]         o_best_index
);

    localparam int AW = $clog2(MAX_SERVERS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cfg;
    logic [CNT_W-1:0]    r_limit, n_limit;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_rd_vld, n_rd_vld;
    logic [CNT_W-1:0]    r_rd_idx;
    logic [ALIVE_N-1:0]  r_alive;
    logic                r_out_vld, n_out_vld;
    logic                r_found;
    logic [PORT_W-1:0]   r_port;
    logic [IDX_W-1:0]    r_idx;

    logic                in_acc;
    logic                upd_ok;
    logic                issue;
    logic                out_free;
    logic                out_load;
    logic                rd_alive;
    logic [ENTRY_W-1:0]  rd_data;
    t_cand               cand;
    t_cmp_ctl            cmp_ctl;
    logic                have;
    logic [CNT_W-1:0]    best_idx;
    logic [PORT_W-1:0]   best_port;

    // handshake decode
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign upd_ok     = in_acc && !i_kind
                        && (32'(i_entry_index) < 32'(MAX_SERVERS));
    assign issue      = (r_state == ST_SCAN) && (r_cnt < r_limit);
    assign out_free   = !r_out_vld || !i_out_stall;
    assign out_load   = (r_state == ST_FIN) && out_free;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CNT_W'(1);
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // alive marks, one per entry index value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '0;
        end else if (upd_ok) begin
            r_alive[i_entry_index] <= i_server_alive;
        end
    end

    // port and count storage
    llss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SERVERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (upd_ok),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata ({i_server_port, i_total_count, i_fail_count}),
        .i_raddr (AW'(r_cnt)),
        .o_rdata (rd_data)
    );

    // candidate from the read issued last cycle
    assign rd_alive   = (r_rd_idx < CNT_W'(ALIVE_N)) && r_alive[r_rd_idx[IDX_W-1:0]];
    assign cand.idx   = r_rd_idx;
    assign cand.port  = rd_data[ENTRY_W-1 -: PORT_W];
    assign cand.total = rd_data[2*CNT32_W-1 -: CNT32_W];
    assign cand.fail  = rd_data[CNT32_W-1:0];

    assign cmp_ctl.clear = in_acc && i_kind;
    assign cmp_ctl.load  = r_rd_vld && rd_alive;

    llss_cmp u_cmp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (cmp_ctl),
        .i_cand      (cand),
        .o_have      (have),
        .o_best_idx  (best_idx),
        .o_best_port (best_port)
    );

    // scan sequencer
    always_comb begin
        n_state   = r_state;
        n_limit   = r_limit;
        n_cnt     = r_cnt;
        n_rd_vld  = issue;
        n_out_vld = r_out_vld;
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_kind) begin
                    n_state = ST_SCAN;
                    n_cnt   = '0;
                    if (32'(r_cfg) > 32'(MAX_SERVERS)) begin
                        n_limit = CNT_W'(MAX_SERVERS);
                    end else begin
                        n_limit = r_cfg;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (!r_rd_vld) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_limit   <= '0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_limit   <= n_limit;
            r_cnt     <= n_cnt;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // read tag and output payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_idx <= r_cnt;
        end
        if (out_load) begin
            r_found <= have;
            r_port  <= have ? best_port : '0;
            r_idx   <= have ? best_idx[IDX_W-1:0] : '0;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_found      = r_found;
    assign o_best_port  = r_port;
    assign o_best_index = r_idx;

`ifndef SYNTH
    // a not-found beat carries zero port and index
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_best_port == '0) && (o_best_index == '0))
        else $error("not-found result with nonzero payload");

    // reads are only in flight during a scan
    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_SCAN))
        else $error("table read outside scan");

    // scan counter never passes the limit
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cnt <= r_limit))
        else $error("scan counter past limit");

    // an accepted select starts a scan
    a_sel_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_kind |=> (r_state == ST_SCAN) && (r_cnt == '0))
        else $error("select did not start a scan");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/llss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module llss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/llss_cmp.sv
// Shared compare unit: keeps the best entry seen so far during a scan.
`timescale 1ns / 1ps
`default_nettype none

module llss_cmp
    import llss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmp_ctl          i_ctl,
    input  wire t_cand             i_cand,
    output logic                   o_have,
    output logic [CNT_W-1:0]       o_best_idx,
    output logic [PORT_W-1:0]      o_best_port
);

    logic                r_have;
    logic [CNT_W-1:0]    r_best_idx;
    logic [PORT_W-1:0]   r_best_port;
    logic [CNT32_W-1:0]  r_best_total;
    logic [CNT32_W-1:0]  r_best_fail;
    logic                take;

    // fewer total wins, then fewer failures; ties keep the earlier entry
    always_comb begin
        take = !r_have
            || (i_cand.total < r_best_total)
            || ((i_cand.total == r_best_total) && (i_cand.fail < r_best_fail));
    end

    // have flag is control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have <= 1'b0;
        end else if (i_ctl.load) begin
            r_have <= 1'b1;
        end
    end

    // best-so-far payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && take && !i_ctl.clear) begin
            r_best_idx   <= i_cand.idx;
            r_best_port  <= i_cand.port;
            r_best_total <= i_cand.total;
            r_best_fail  <= i_cand.fail;
        end
    end

    assign o_have      = r_have;
    assign o_best_idx  = r_best_idx;
    assign o_best_port = r_best_port;

endmodule

`default_nettype wire
